// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the option tag matcher RTL.
// Included by files that carry concurrent assertions; needs clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define OTKM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("otkm assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define OTKM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("otkm assertion failed");

`endif

// ===== rtl/core/otkm_pkg.sv =====
// Package for the option tag matcher: payload types, tag tables and match helpers.
// No dependencies.
`timescale 1ns / 1ps

package otkm_pkg;

   localparam int NumTags = 6;
   localparam int TagMaxLen = 9;

   localparam logic [3:0] LenMax = 4'd15;

   localparam logic [7:0] ChSpace = 8'h20;
   localparam logic [7:0] ChTab = 8'h09;
   localparam logic [7:0] ChCr = 8'h0D;
   localparam logic [7:0] ChLf = 8'h0A;
   localparam logic [7:0] ChComma = 8'h2C;
   localparam logic [7:0] FoldBit = 8'h20;
   localparam logic [7:0] UpperA = 8'h41;
   localparam logic [7:0] UpperZ = 8'h5A;

   typedef logic [NumTags-1:0] otkm_mask_type;
   typedef logic [3:0] otkm_len_type;

   // bit 0 path, 1 100rel, 2 timer, 3 eventlist, 4 gruu, 5 outbound
   localparam logic [0:NumTags-1][0:TagMaxLen-1][7:0] TagText = '{
      '{"p", "a", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"1", "0", "0", "r", "e", "l", 8'h00, 8'h00, 8'h00},
      '{"t", "i", "m", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "v", "e", "n", "t", "l", "i", "s", "t"},
      '{"g", "r", "u", "u", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "u", "t", "b", "o", "u", "n", "d", 8'h00}
   };
   localparam logic [0:NumTags-1][3:0] TagLen = '{4'd4, 4'd6, 4'd5, 4'd9, 4'd4, 4'd8};
   // set: compare after OR 0x20; clear: fold A..Z only
   localparam otkm_mask_type TagOrFold = 6'b000111;

   typedef struct packed {
      logic [7:0] body_byte;
      logic       byte_valid;
      logic       end_of_body;
   } otkm_item_type;

   typedef struct packed {
      logic          valid;
      otkm_item_type item;
   } otkm_stage_type;

   typedef struct packed {
      logic          valid;
      otkm_mask_type tag_mask;
   } otkm_result_type;

   function automatic logic is_token_break(input logic [7:0] c);
      return (c == ChSpace) || (c == ChTab) || (c == ChCr) || (c == ChLf) || (c == ChComma);
   endfunction

   function automatic logic [7:0] fold_ascii(input logic [7:0] c);
      if ((c >= UpperA) && (c <= UpperZ)) begin
         return c | FoldBit;
      end
      return c;
   endfunction

   function automatic logic [7:0] tag_char(input int tag, input otkm_len_type pos);
      if (pos < 4'(TagMaxLen)) begin
         return TagText[tag][pos];
      end
      return 8'h00;
   endfunction

   // tags completed by a token of length len that still matches
   function automatic otkm_mask_type token_hits(input otkm_len_type len,
                                                input otkm_mask_type match);
      otkm_mask_type hits;
      hits = '0;
      for (int t = 0; t < NumTags; t++) begin
         hits[t] = match[t] && (len != 4'd0) && (len == TagLen[t]);
      end
      return hits;
   endfunction

endpackage

// ===== rtl/core/otkm_if.sv =====
// Request and response channel interfaces for the option tag matcher.
// Depends on otkm_pkg for the mask width.
`timescale 1ns / 1ps

interface otkm_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       byte_valid;
   logic       end_of_body;

   modport source (output valid, output body_byte, output byte_valid, output end_of_body,
                   input ready);
   modport sink (input valid, input body_byte, input byte_valid, input end_of_body,
                 output ready);
endinterface

interface otkm_rsp_if;
   logic                   valid;
   logic                   ready;
   otkm_pkg::otkm_mask_type tag_mask;

   modport source (output valid, output tag_mask, input ready);
   modport sink (input valid, input tag_mask, output ready);
endinterface

// ===== rtl/core/otkm_in_stage.sv =====
// Input register of the option tag matcher: captures one request per cycle, except while a final byte waits.
// Depends on otkm_pkg and otkm_req_if.
`timescale 1ns / 1ps

module otkm_in_stage (
   input  logic                     clock,
   input  logic                     reset,
   otkm_req_if.sink                 req,
   input  logic                     out_busy,
   output otkm_pkg::otkm_stage_type stage,
   output logic                     stage_fire
);
   import otkm_pkg::*;

   logic          valid_ff, valid_in;
   otkm_item_type item_ff, item_in;

   // a final byte waits while the response register still holds an untaken mask
   assign stage_fire = valid_ff && !(item_ff.end_of_body && out_busy);
   assign req.ready = !valid_ff || stage_fire;

   always_comb begin
      valid_in = valid_ff;
      item_in = item_ff;
      if (req.ready) begin
         valid_in = req.valid;
         item_in = '{body_byte: req.body_byte, byte_valid: req.byte_valid,
                     end_of_body: req.end_of_body};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign stage = '{valid: valid_ff, item: item_ff};

endmodule

// ===== rtl/core/otkm_match_core.sv =====
// Token state and per-tag byte comparison of the option tag matcher.
// Depends on otkm_pkg.
`timescale 1ns / 1ps

module otkm_match_core (
   input  logic                      clock,
   input  logic                      reset,
   input  otkm_pkg::otkm_stage_type  stage,
   input  logic                      stage_fire,
   output otkm_pkg::otkm_result_type result
);
   import otkm_pkg::*;

   otkm_len_type  len_ff, len_in, len_a;
   otkm_mask_type match_ff, match_in, match_a;
   otkm_mask_type found_ff, found_in, found_a, found_b;
   logic [7:0]    c, got;

   assign c = stage.item.body_byte;

   always_comb begin
      len_a = len_ff;
      match_a = match_ff;
      found_a = found_ff;
      got = 8'h00;
      if (stage.item.byte_valid) begin
         if (is_token_break(c)) begin
            found_a = found_ff | token_hits(len_ff, match_ff);
            len_a = '0;
            match_a = '1;
         end else begin
            for (int t = 0; t < NumTags; t++) begin
               got = TagOrFold[t] ? (c | FoldBit) : fold_ascii(c);
               if (!((len_ff < TagLen[t]) && (got == tag_char(t, len_ff)))) begin
                  match_a[t] = 1'b0;
               end
            end
            if (len_ff != LenMax) begin
               len_a = len_ff + 4'd1;
            end
         end
      end
      found_b = found_a | token_hits(len_a, match_a);
   end

   always_comb begin
      len_in = len_ff;
      match_in = match_ff;
      found_in = found_ff;
      if (stage_fire) begin
         if (stage.item.end_of_body) begin
            len_in = '0;
            match_in = '1;
            found_in = '0;
         end else begin
            len_in = len_a;
            match_in = match_a;
            found_in = found_a;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         match_ff <= '1;
         found_ff <= '0;
      end else begin
         len_ff <= len_in;
         match_ff <= match_in;
         found_ff <= found_in;
      end
   end

   assign result = '{valid: stage_fire && stage.item.end_of_body, tag_mask: found_b};

endmodule

// ===== rtl/core/otkm_out_reg.sv =====
// Response register of the option tag matcher: holds one mask until taken.
// Depends on otkm_pkg and otkm_rsp_if.
`timescale 1ns / 1ps

module otkm_out_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  otkm_pkg::otkm_result_type result,
   otkm_rsp_if.source                rsp,
   output logic                      out_busy
);
   import otkm_pkg::*;

   logic          valid_ff, valid_in;
   otkm_mask_type mask_ff, mask_in;

   always_comb begin
      valid_in = valid_ff && !rsp.ready;
      mask_in = mask_ff;
      if (result.valid) begin
         valid_in = 1'b1;
         mask_in = result.tag_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      mask_ff <= mask_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.tag_mask = mask_ff;
   assign out_busy = valid_ff && !rsp.ready;

endmodule

// ===== rtl/core/option_tag_keyword_matcher_top.sv =====
// Top level of the option tag matcher: input register, match core, response register.
// Depends on otkm_pkg, otkm_if, otkm_in_stage, otkm_match_core, otkm_out_reg.
//
//   channel | dir | payload                                 | handshake
//   req     | in  | body_byte[7:0] byte_valid end_of_body   | valid / ready
//   rsp     | out | tag_mask[5:0], one per end_of_body      | valid / ready
//
// One request per cycle unless a final request waits; the mask passes the input and then the response register.
// Rate is set by the single token update between the input and response registers.
// Synchronous reset clears the token state, the found mask and both valid flags.
// A final request waits in the input register while the response register is stalled;
// other requests keep flowing during a response stall.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module option_tag_keyword_matcher_top (
   input logic      clock,
   input logic      reset,
   otkm_req_if.sink req,
   otkm_rsp_if.source rsp
);
   import otkm_pkg::*;

   otkm_stage_type  stage;
   otkm_result_type result;
   logic            stage_fire;
   logic            out_busy;
   logic            last_stalled;

   otkm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .out_busy   (out_busy),
      .stage      (stage),
      .stage_fire (stage_fire)
   );

   otkm_match_core u_match_core (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .stage_fire (stage_fire),
      .result     (result)
   );

   otkm_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .result   (result),
      .rsp      (rsp),
      .out_busy (out_busy)
   );

   assign last_stalled = stage.valid && stage.item.end_of_body && rsp.valid && !rsp.ready;

   `OTKM_ASSERT_NEXT(a_last_gives_rsp, stage_fire && stage.item.end_of_body, rsp.valid)
   `OTKM_ASSERT_SAME(a_empty_stage_ready, !stage.valid, req.ready)
   `OTKM_ASSERT_SAME(a_last_held_on_stall, last_stalled, !req.ready && !result.valid)

endmodule

// ===== sim/otkm_tag_scoreboard.sv =====
// Scoreboard for the option tag matcher: follows accepted requests, predicts tag masks.
// Compares each accepted response against the oldest predicted mask.
// Depends on otkm_pkg for the mask type.
`timescale 1ns / 1ps

module otkm_tag_scoreboard (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic [7:0]              req_body_byte,
   input  logic                    req_byte_valid,
   input  logic                    req_end_of_body,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  otkm_pkg::otkm_mask_type rsp_tag_mask,
   output int                      mismatch_count,
   output int                      masks_pending
);

   localparam logic [7:0] DELIM_SPACE = 8'h20;
   localparam logic [7:0] DELIM_TAB = 8'h09;
   localparam logic [7:0] DELIM_CR = 8'h0D;
   localparam logic [7:0] DELIM_LF = 8'h0A;
   localparam logic [7:0] DELIM_COMMA = 8'h2C;
   localparam logic [7:0] CASE_BIT = 8'h20;
   localparam logic [7:0] UPPER_A = 8'h41;
   localparam logic [7:0] UPPER_Z = 8'h5A;
   localparam logic [3:0] LEN_CAP = 4'd15;

   localparam logic [7:0] TAG_BYTES [6][9] = '{
      '{"p", "a", "t", "h", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"1", "0", "0", "r", "e", "l", 8'h00, 8'h00, 8'h00},
      '{"t", "i", "m", "e", "r", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "v", "e", "n", "t", "l", "i", "s", "t"},
      '{"g", "r", "u", "u", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "u", "t", "b", "o", "u", "n", "d", 8'h00}
   };
   localparam int TAG_LENGTH [6] = '{4, 6, 5, 9, 4, 8};
   // path, 100rel and timer compare after OR 0x20; the rest fold A..Z only
   localparam logic [5:0] OR_FOLD_TAGS = 6'b000111;

   logic [3:0]              tok_len;
   logic [5:0]              tok_live;
   logic [5:0]              seen_tags;
   otkm_pkg::otkm_mask_type mask_q [$];
   int                      errors = 0;

   function automatic logic is_separator(input logic [7:0] c);
      return (c == DELIM_SPACE) || (c == DELIM_TAB) || (c == DELIM_CR) ||
             (c == DELIM_LF) || (c == DELIM_COMMA);
   endfunction

   task automatic close_token();
      if (tok_len != 4'd0) begin
         for (int t = 0; t < 6; t++) begin
            if (tok_live[t] && (tok_len == TAG_LENGTH[t])) begin
               seen_tags[t] = 1'b1;
            end
         end
      end
      tok_len = 4'd0;
      tok_live = '1;
   endtask

   task automatic absorb_byte(input logic [7:0] c);
      logic [7:0] got;
      logic       ok;
      for (int t = 0; t < 6; t++) begin
         ok = 1'b0;
         if (tok_len < TAG_LENGTH[t]) begin
            if (OR_FOLD_TAGS[t]) begin
               got = c | CASE_BIT;
            end else if ((c >= UPPER_A) && (c <= UPPER_Z)) begin
               got = c | CASE_BIT;
            end else begin
               got = c;
            end
            ok = (got == TAG_BYTES[t][tok_len]);
         end
         if (!ok) begin
            tok_live[t] = 1'b0;
         end
      end
      if (tok_len != LEN_CAP) begin
         tok_len = tok_len + 4'd1;
      end
   endtask

   task automatic flag_mismatch(input string what, input otkm_pkg::otkm_mask_type want,
                                input otkm_pkg::otkm_mask_type got);
      errors++;
      if (errors <= 10) begin
         $display("%0t: tag_mask %s: expected %b, got %b", $time, what, want, got);
      end
   endtask

   always @(posedge clock) begin
      otkm_pkg::otkm_mask_type want;
      if (reset) begin
         tok_len = 4'd0;
         tok_live = '1;
         seen_tags = '0;
         mask_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (mask_q.size() == 0) begin
               flag_mismatch("unexpected response", 'x, rsp_tag_mask);
            end else begin
               want = mask_q.pop_front();
               if (rsp_tag_mask !== want) begin
                  flag_mismatch("wrong value", want, rsp_tag_mask);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_byte_valid) begin
               if (is_separator(req_body_byte)) begin
                  close_token();
               end else begin
                  absorb_byte(req_body_byte);
               end
            end
            if (req_end_of_body) begin
               close_token();
               mask_q.push_back(seen_tags);
               seen_tags = '0;
            end
         end
      end
      mismatch_count <= errors;
      masks_pending <= mask_q.size();
   end

endmodule

// ===== sim/option_tag_keyword_matcher_top_test.sv =====
// Testbench top for the option tag matcher: clock, reset, request and response stimulus.
// Sends directed and random header bodies; otkm_tag_scoreboard does the checking.
// Depends on otkm_pkg, otkm_if, option_tag_keyword_matcher_top and otkm_tag_scoreboard.
`timescale 1ns / 1ps

module option_tag_keyword_matcher_top_test;

   import otkm_pkg::*;

   localparam int ITEM_TARGET = 600;
   localparam int BODY_TARGET = 50;
   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 12;

   localparam logic [7:0] SEPARATORS [5] = '{ChSpace, ChTab, ChCr, ChLf, ChComma};

   logic clock = 1'b0;
   logic reset = 1'b1;

   otkm_req_if req_ch ();
   otkm_rsp_if rsp_ch ();

   int mismatch_count;
   int masks_pending;
   int cycle_count = 0;
   int items_sent = 0;
   int bodies_sent = 0;
   int stall_left = 0;
   int calm_left = 0;
   int stall_pick;
   logic calm = 1'b0;
   logic [7:0] body_q [$];
   string tag_words [6] = '{"path", "100rel", "timer", "eventlist", "gruu", "outbound"};

   always #5 clock = ~clock;

   option_tag_keyword_matcher_top u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   otkm_tag_scoreboard u_scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_body_byte   (req_ch.body_byte),
      .req_byte_valid  (req_ch.byte_valid),
      .req_end_of_body (req_ch.end_of_body),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_tag_mask    (rsp_ch.tag_mask),
      .mismatch_count  (mismatch_count),
      .masks_pending   (masks_pending)
   );

   function automatic int idle_cycles(input logic quiet);
      int r;
      if (quiet) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end
      if (r < 88) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 24);
   endfunction

   // stretches with no idling on either side
   always @(posedge clock) begin
      if (calm_left == 0) begin
         calm <= ($urandom_range(0, 3) == 0);
         calm_left <= $urandom_range(30, 300);
      end else begin
         calm_left <= calm_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 1) begin
         stall_left <= stall_left - 1;
      end else if (stall_left == 1) begin
         rsp_ch.ready <= 1'b1;
         stall_left <= 0;
      end else begin
         stall_pick = ($urandom_range(0, 2) == 0) ? idle_cycles(calm) : 0;
         rsp_ch.ready <= (stall_pick == 0);
         stall_left <= stall_pick;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("option_tag_keyword_matcher_top_test NOT OK");
         $finish;
      end
   end

   task automatic send_item(input logic [7:0] b, input logic bv, input logic eob);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.body_byte <= b;
      req_ch.byte_valid <= bv;
      req_ch.end_of_body <= eob;
      @(posedge clock);
      while (!req_ch.ready) begin
         @(posedge clock);
      end
      if (bv || eob) begin
         items_sent++;
      end
      gap = idle_cycles(calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_body(input logic separate_end);
      int n;
      n = body_q.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 6) begin
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end
         send_item(body_q[i], 1'b1, !separate_end && (i == n - 1));
      end
      if (separate_end || (n == 0)) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
      body_q.delete();
      bodies_sent++;
   endtask

   task automatic add_separators();
      int n;
      n = ($urandom_range(0, 99) < 15) ? 0 : $urandom_range(1, 3);
      repeat (n) body_q.push_back(SEPARATORS[$urandom_range(0, 4)]);
   endtask

   // tag spelling with case flips, sometimes damaged, shortened or lengthened
   task automatic add_tag_word(input int idx);
      logic [7:0] c;
      int base;
      int len;
      base = body_q.size();
      len = tag_words[idx].len();
      for (int i = 0; i < len; i++) begin
         c = tag_words[idx][i];
         if ($urandom_range(0, 3) == 0) begin
            c = c ^ 8'h20;
         end
         body_q.push_back(c);
      end
      if ($urandom_range(0, 99) < 12) begin
         body_q[base + $urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 99) < 8) begin
         void'(body_q.pop_back());
      end else if ($urandom_range(0, 99) < 8) begin
         body_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic add_junk_token();
      int len;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
      repeat (len) body_q.push_back(8'($urandom_range(0, 255)));
   endtask

   initial begin
      int tokens;
      req_ch.valid <= 1'b0;
      req_ch.body_byte <= 8'h00;
      req_ch.byte_valid <= 1'b0;
      req_ch.end_of_body <= 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty body
      send_body(1'b0);
      // final byte carries data
      body_q = '{"G", "r", "U", "u"};
      send_body(1'b0);
      // 100rel through OR fold of control bytes, then extreme byte values
      body_q = '{8'h11, 8'h10, 8'h30, "R", "e", "L", ChTab, 8'h00, 8'hFF};
      send_body(1'b1);
      // item without data, then every delimiter but tab
      send_item(8'hFF, 1'b0, 1'b0);
      body_q = '{ChComma, ChCr, ChLf, ChSpace, "t", "I", "M", "E", "R"};
      send_body(1'b0);

      while ((items_sent < ITEM_TARGET) || (bodies_sent < BODY_TARGET)) begin
         tokens = $urandom_range(0, 4);
         if ($urandom_range(0, 99) < 30) begin
            add_separators();
         end
         for (int k = 0; k < tokens; k++) begin
            if (k != 0) begin
               add_separators();
            end
            if ($urandom_range(0, 99) < 65) begin
               add_tag_word($urandom_range(0, 5));
            end else begin
               add_junk_token();
            end
         end
         if ($urandom_range(0, 99) < 25) begin
            add_separators();
         end
         send_body(1'($urandom_range(0, 1)));
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      while (masks_pending != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("option_tag_keyword_matcher_top_test OK");
      end else begin
         $display("option_tag_keyword_matcher_top_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/otkm_pkg.sv
rtl/core/otkm_if.sv
rtl/core/otkm_in_stage.sv
rtl/core/otkm_match_core.sv
rtl/core/otkm_out_reg.sv
rtl/core/option_tag_keyword_matcher_top.sv
sim/otkm_tag_scoreboard.sv
sim/option_tag_keyword_matcher_top_test.sv
